// ===== rtl/core/bfeu_pkg.sv =====
// ----------------------------------------------------------------------------
// bfeu_pkg
// Shared sizes, opcode characters and status codes of the execute unit.
// ----------------------------------------------------------------------------
package bfeu_pkg;

  // Storage sizes
  localparam int unsigned TAPE_DEPTH     = 1024;
  localparam int unsigned STACK_DEPTH    = 64;
  localparam int unsigned POSITION_WIDTH = 16;

  // Derived widths
  localparam int unsigned TP_W  = $clog2(TAPE_DEPTH);
  localparam int unsigned SP_W  = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SKIP_W = 16;

  localparam logic [TP_W-1:0]   TAPE_LAST  = TP_W'(TAPE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  STACK_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [SKIP_W-1:0] SKIP_MAX   = '1;

  // Program characters that act
  localparam logic [7:0] OP_PLUS  = 8'd43;
  localparam logic [7:0] OP_COMMA = 8'd44;
  localparam logic [7:0] OP_MINUS = 8'd45;
  localparam logic [7:0] OP_DOT   = 8'd46;
  localparam logic [7:0] OP_LEFT  = 8'd60;
  localparam logic [7:0] OP_RIGHT = 8'd62;
  localparam logic [7:0] OP_OPEN  = 8'd91;
  localparam logic [7:0] OP_CLOSE = 8'd93;

  // Result status
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNMATCHED  = 2'd1,
    ST_STACK_FULL = 2'd2,
    ST_TAPE_END   = 2'd3
  } status_e;

  typedef logic [POSITION_WIDTH-1:0] pos_t;

endpackage

// ===== rtl/core/brainfuck_execute_unit_top.sv =====
// ----------------------------------------------------------------------------
// brainfuck_execute_unit_top
// Executes one program character per item against a byte tape and loop stack.
// ----------------------------------------------------------------------------
// Takes one program character per clock cycle unless the result channel stalls,
// and returns one result per item through the input register, then the result
// register. The rate is set by the single execute stage: the current tape cell
// and the loop-stack top are held in registers, and the tape and stack memories
// are read ahead at the address the next item will use, so pointer moves and
// pops do not stall. After reset the tape memory is cleared in a pass over all
// TAPE_DEPTH cells (1024), during which item_ready_o stays low.
// ----------------------------------------------------------------------------
module brainfuck_execute_unit_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input item channel
  input  logic                                  item_valid_i,
  output logic                                  item_ready_o,
  input  logic [7:0]                            opcode_i,
  input  logic [bfeu_pkg::POSITION_WIDTH-1:0]   position_i,
  input  logic [7:0]                            in_byte_i,
  // result item channel
  output logic                                  result_valid_o,
  input  logic                                  result_ready_i,
  output logic [bfeu_pkg::POSITION_WIDTH-1:0]   next_position_o,
  output logic                                  out_valid_o,
  output logic [7:0]                            out_byte_o,
  output logic [1:0]                            status_o,
  output logic                                  skipping_o
);

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  logic                              clr_active_q;
  logic [bfeu_pkg::TP_W-1:0]         clr_addr_q;

  logic                              in_vld_q;
  logic [7:0]                        in_op_q;
  bfeu_pkg::pos_t                    in_pos_q;
  logic [7:0]                        in_byte_q;

  logic                              res_vld_q;
  bfeu_pkg::pos_t                    res_next_pos_q;
  logic                              res_out_valid_q;
  logic [7:0]                        res_out_byte_q;
  bfeu_pkg::status_e                 res_status_q;
  logic                              res_skipping_q;

  logic [bfeu_pkg::TP_W-1:0]         tp_q, tp_d;
  logic [bfeu_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [bfeu_pkg::SKIP_W-1:0]       skip_q, skip_d;
  logic [7:0]                        cell_q, cell_d;
  logic                              cell_sel_q, cell_sel_d;
  bfeu_pkg::pos_t                    top_q, top_d;
  logic                              top_sel_q, top_sel_d;

  logic [7:0]                        tape_mem [bfeu_pkg::TAPE_DEPTH];
  logic [7:0]                        tape_rdata_q;
  bfeu_pkg::pos_t                    stk_mem [bfeu_pkg::STACK_DEPTH];
  bfeu_pkg::pos_t                    stk_rdata_q;

  logic                              out_free;
  logic                              exec;
  logic                              accept;

  logic [7:0]                        cell_cur;
  bfeu_pkg::pos_t                    top_cur;
  bfeu_pkg::pos_t                    seq_pos;
  logic                              cell_we;
  logic                              push_we;
  logic                              pop;
  logic                              tape_we;
  logic [bfeu_pkg::TP_W-1:0]         tape_waddr;
  logic [7:0]                        tape_wdata;
  logic [bfeu_pkg::CNT_W-1:0]        cnt_dec;

  bfeu_pkg::pos_t                    next_pos;
  logic                              emit;
  bfeu_pkg::status_e                 status;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign out_free     = !res_vld_q || result_ready_i;
  assign exec         = in_vld_q && out_free;
  assign item_ready_o = !clr_active_q && (!in_vld_q || out_free);
  assign accept       = item_valid_i && item_ready_o;

  // Current cell and stack top: from the memory right after a move or pop
  assign cell_cur = cell_sel_q ? tape_rdata_q : cell_q;
  assign top_cur  = top_sel_q ? stk_rdata_q : top_q;
  assign seq_pos  = in_pos_q + bfeu_pkg::pos_t'(1);

  // --------------------------------------------------------------------------
  // Execute
  // --------------------------------------------------------------------------
  always_comb begin
    tp_d     = tp_q;
    cnt_d    = cnt_q;
    skip_d   = skip_q;
    cell_d   = cell_cur;
    top_d    = top_cur;
    cell_we  = 1'b0;
    push_we  = 1'b0;
    pop      = 1'b0;
    next_pos = seq_pos;
    emit     = 1'b0;
    status   = bfeu_pkg::ST_OK;

    if (exec) begin
      if (skip_q != '0) begin
        // skipping a loop body: only count brackets
        if (in_op_q == bfeu_pkg::OP_OPEN) begin
          if (skip_q != bfeu_pkg::SKIP_MAX) begin
            skip_d = skip_q + bfeu_pkg::SKIP_W'(1);
          end
        end else if (in_op_q == bfeu_pkg::OP_CLOSE) begin
          skip_d = skip_q - bfeu_pkg::SKIP_W'(1);
        end
      end else begin
        case (in_op_q)
          bfeu_pkg::OP_PLUS: begin
            cell_d  = cell_cur + 8'd1;
            cell_we = 1'b1;
          end
          bfeu_pkg::OP_MINUS: begin
            cell_d  = cell_cur - 8'd1;
            cell_we = 1'b1;
          end
          bfeu_pkg::OP_COMMA: begin
            cell_d  = in_byte_q;
            cell_we = 1'b1;
          end
          bfeu_pkg::OP_LEFT: begin
            if (tp_q != '0) begin
              tp_d = tp_q - bfeu_pkg::TP_W'(1);
            end
          end
          bfeu_pkg::OP_RIGHT: begin
            if (tp_q != bfeu_pkg::TAPE_LAST) begin
              tp_d = tp_q + bfeu_pkg::TP_W'(1);
            end else begin
              status = bfeu_pkg::ST_TAPE_END;
            end
          end
          bfeu_pkg::OP_DOT: begin
            emit = 1'b1;
          end
          bfeu_pkg::OP_OPEN: begin
            if (cell_cur != 8'd0) begin
              if (cnt_q != bfeu_pkg::STACK_FULL) begin
                push_we = 1'b1;
                top_d   = seq_pos;
                cnt_d   = cnt_q + bfeu_pkg::CNT_W'(1);
              end else begin
                status = bfeu_pkg::ST_STACK_FULL;
              end
            end else begin
              skip_d = bfeu_pkg::SKIP_W'(1);
            end
          end
          bfeu_pkg::OP_CLOSE: begin
            if (cnt_q == '0) begin
              status = bfeu_pkg::ST_UNMATCHED;
            end else if (cell_cur != 8'd0) begin
              next_pos = top_cur;
            end else begin
              pop   = 1'b1;
              cnt_d = cnt_q - bfeu_pkg::CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // After a move or pop the new value arrives from memory next cycle
  assign cell_sel_d = exec && (tp_d != tp_q);
  assign top_sel_d  = pop;
  assign cnt_dec    = cnt_d - bfeu_pkg::CNT_W'(1);

  // --------------------------------------------------------------------------
  // Tape memory: clearing pass after reset, then cell write-through
  // --------------------------------------------------------------------------
  assign tape_we    = clr_active_q || cell_we;
  assign tape_waddr = clr_active_q ? clr_addr_q : tp_q;
  assign tape_wdata = clr_active_q ? 8'd0 : cell_d;

  always_ff @(posedge clk_i) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
    tape_rdata_q <= tape_mem[tp_d];
  end

  // --------------------------------------------------------------------------
  // Loop stack memory: push at count, prefetch entry below the new count
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (push_we) begin
      stk_mem[cnt_q[bfeu_pkg::SP_W-1:0]] <= seq_pos;
    end
    stk_rdata_q <= stk_mem[cnt_dec[bfeu_pkg::SP_W-1:0]];
  end

  // --------------------------------------------------------------------------
  // Clearing pass
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      if (clr_addr_q == bfeu_pkg::TAPE_LAST) begin
        clr_active_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + bfeu_pkg::TP_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Architectural state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q       <= '0;
      cnt_q      <= '0;
      skip_q     <= '0;
      cell_q     <= '0;
      cell_sel_q <= 1'b0;
      top_sel_q  <= 1'b0;
    end else begin
      tp_q       <= tp_d;
      cnt_q      <= cnt_d;
      skip_q     <= skip_d;
      cell_q     <= cell_d;
      cell_sel_q <= cell_sel_d;
      top_sel_q  <= top_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (exec) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q   <= opcode_i;
      in_pos_q  <= position_i;
      in_byte_q <= in_byte_i;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (out_free) begin
      res_vld_q <= exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_next_pos_q  <= next_pos;
      res_out_valid_q <= emit;
      res_out_byte_q  <= emit ? cell_cur : 8'd0;
      res_status_q    <= status;
      res_skipping_q  <= (skip_d != '0);
    end
  end

  assign result_valid_o  = res_vld_q;
  assign next_position_o = res_next_pos_q;
  assign out_valid_o     = res_out_valid_q;
  assign out_byte_o      = res_out_byte_q;
  assign status_o        = res_status_q;
  assign skipping_o      = res_skipping_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives program characters into the execute unit and checks every result
// against a cycle-free model of the tape, tape pointer, loop stack and skip
// counter. Directed corner cases come first, then a stack overflow and a walk
// to the tape top. Random program fragments follow in phases with different
// sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 75;

  typedef struct packed {
    logic [7:0]     opcode;
    bfeu_pkg::pos_t position;
    logic [7:0]     in_byte;
  } char_item_t;

  typedef struct {
    bfeu_pkg::pos_t    next_position;
    logic              out_valid;
    logic [7:0]        out_byte;
    bfeu_pkg::status_e status;
    logic              skipping;
  } exec_result_t;

  logic           clk_i          = 1'b0;
  logic           rst_ni         = 1'b0;
  logic           item_valid_i   = 1'b0;
  logic           item_ready_o;
  logic [7:0]     opcode_i       = 8'h00;
  bfeu_pkg::pos_t position_i     = '0;
  logic [7:0]     in_byte_i      = 8'h00;
  logic           result_valid_o;
  logic           result_ready_i = 1'b0;
  bfeu_pkg::pos_t next_position_o;
  logic           out_valid_o;
  logic [7:0]     out_byte_o;
  logic [1:0]     status_o;
  logic           skipping_o;

  brainfuck_execute_unit_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid_i),
    .item_ready_o    (item_ready_o),
    .opcode_i        (opcode_i),
    .position_i      (position_i),
    .in_byte_i       (in_byte_i),
    .result_valid_o  (result_valid_o),
    .result_ready_i  (result_ready_i),
    .next_position_o (next_position_o),
    .out_valid_o     (out_valid_o),
    .out_byte_o      (out_byte_o),
    .status_o        (status_o),
    .skipping_o      (skipping_o)
  );

  // Stimulus and expectation stores
  char_item_t     pending_chars [$];
  exec_result_t   expected_results [$];
  logic           item_fire      = 1'b0;
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    hold_reqs      = 0;
  int unsigned    err_count      = 0;
  int unsigned    cycle_count    = 0;
  int unsigned    act_count      = 0;
  bfeu_pkg::pos_t prog_pos       = '0;

  // Model state of the interpreter
  logic [7:0]                  tape_mem [bfeu_pkg::TAPE_DEPTH] = '{default: 8'h00};
  logic [bfeu_pkg::TP_W-1:0]   tape_ptr    = '0;
  bfeu_pkg::pos_t              loop_ret [bfeu_pkg::STACK_DEPTH];
  int unsigned                 stack_count = 0;
  logic [bfeu_pkg::SKIP_W-1:0] skip_level  = '0;

  // Executes one program character on the model and returns its result
  function automatic exec_result_t execute_char(input logic [7:0] op,
                                                input bfeu_pkg::pos_t pos,
                                                input logic [7:0] data);
    exec_result_t r;
    r.next_position = pos + 1'b1;
    r.out_valid     = 1'b0;
    r.out_byte      = 8'h00;
    r.status        = bfeu_pkg::ST_OK;
    if (skip_level != '0) begin
      // inside a skipped body only brackets count
      if (op == bfeu_pkg::OP_OPEN) begin
        if (skip_level != bfeu_pkg::SKIP_MAX) skip_level++;
      end else if (op == bfeu_pkg::OP_CLOSE) begin
        skip_level--;
      end
    end else begin
      case (op)
        bfeu_pkg::OP_PLUS:  tape_mem[tape_ptr] = tape_mem[tape_ptr] + 8'd1;
        bfeu_pkg::OP_MINUS: tape_mem[tape_ptr] = tape_mem[tape_ptr] - 8'd1;
        bfeu_pkg::OP_LEFT: begin
          if (tape_ptr != '0) tape_ptr--;
        end
        bfeu_pkg::OP_RIGHT: begin
          if (tape_ptr != bfeu_pkg::TAPE_LAST) tape_ptr++;
          else r.status = bfeu_pkg::ST_TAPE_END;
        end
        bfeu_pkg::OP_DOT: begin
          r.out_valid = 1'b1;
          r.out_byte  = tape_mem[tape_ptr];
        end
        bfeu_pkg::OP_COMMA: tape_mem[tape_ptr] = data;
        bfeu_pkg::OP_OPEN: begin
          if (tape_mem[tape_ptr] == 8'h00) begin
            skip_level = bfeu_pkg::SKIP_W'(1);
          end else if (stack_count < bfeu_pkg::STACK_DEPTH) begin
            loop_ret[stack_count] = r.next_position;
            stack_count++;
          end else begin
            r.status = bfeu_pkg::ST_STACK_FULL;
          end
        end
        bfeu_pkg::OP_CLOSE: begin
          if (stack_count == 0) r.status = bfeu_pkg::ST_UNMATCHED;
          else if (tape_mem[tape_ptr] != 8'h00) r.next_position = loop_ret[stack_count - 1];
          else stack_count--;
        end
        default: ;
      endcase
    end
    r.skipping = (skip_level != '0);
    return r;
  endfunction

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Input driver: next item from the queue, with random gaps
  always @(negedge clk_i) begin : drive_items
    char_item_t nxt;
    if (!item_valid_i || item_fire) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_chars.pop_front();
        opcode_i     <= nxt.opcode;
        position_i   <= nxt.position;
        in_byte_i    <= nxt.in_byte;
        item_valid_i <= 1'b1;
      end else begin
        item_valid_i <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, plus long hold-offs on request
  always @(negedge clk_i) begin : drive_ready
    int unsigned hold_seen;
    int unsigned hold_left;
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_ready_i <= 1'b0;
    end else begin
      result_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on input handshake, compare on result handshake
  always @(posedge clk_i) begin : monitor
    exec_result_t want;
    item_fire <= rst_ni && item_valid_i && item_ready_o;
    if (rst_ni) begin
      if (item_valid_i && item_ready_o) begin
        expected_results.push_back(execute_char(opcode_i, position_i, in_byte_i));
      end
      if (result_valid_o && result_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation pending: next_position %h",
                 next_position_o);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (next_position_o !== want.next_position) begin
            $error("next_position mismatch: expected %h, got %h",
                   want.next_position, next_position_o);
            err_count++;
          end
          if (out_valid_o !== want.out_valid) begin
            $error("out_valid mismatch: expected %b, got %b", want.out_valid, out_valid_o);
            err_count++;
          end
          if (out_byte_o !== want.out_byte) begin
            $error("out_byte mismatch: expected %h, got %h", want.out_byte, out_byte_o);
            err_count++;
          end
          if (status_o !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status_o);
            err_count++;
          end
          if (skipping_o !== want.skipping) begin
            $error("skipping mismatch: expected %b, got %b", want.skipping, skipping_o);
            err_count++;
          end
        end
      end
    end
  end

  // Queue one program character at the running program offset
  task automatic add_char(input logic [7:0] op, input logic [7:0] data);
    char_item_t c;
    c.opcode   = op;
    c.position = prog_pos;
    c.in_byte  = data;
    pending_chars.push_back(c);
    prog_pos = prog_pos + 1'b1;
    if (op inside {bfeu_pkg::OP_PLUS, bfeu_pkg::OP_MINUS, bfeu_pkg::OP_LEFT,
                   bfeu_pkg::OP_RIGHT, bfeu_pkg::OP_DOT, bfeu_pkg::OP_COMMA,
                   bfeu_pkg::OP_OPEN, bfeu_pkg::OP_CLOSE}) act_count++;
  endtask

  // Byte with a strong bias to zero so loops both enter and fall through
  function automatic logic [7:0] rand_byte();
    return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
  endfunction

  // Well-formed fragment: balanced brackets, random body
  task automatic gen_program(input int unsigned len);
    int unsigned open;
    logic [7:0]  op;
    open = 0;
    if ($urandom_range(2) == 0) prog_pos = bfeu_pkg::pos_t'($urandom_range(16'hFFFF));
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(10))
        0:       op = bfeu_pkg::OP_PLUS;
        1:       op = bfeu_pkg::OP_MINUS;
        2:       op = bfeu_pkg::OP_LEFT;
        3:       op = bfeu_pkg::OP_RIGHT;
        4:       op = bfeu_pkg::OP_DOT;
        5:       op = bfeu_pkg::OP_COMMA;
        6, 7:    op = bfeu_pkg::OP_OPEN;
        8, 9:    op = (open != 0) ? bfeu_pkg::OP_CLOSE : bfeu_pkg::OP_PLUS;
        default: op = 8'($urandom_range(255));
      endcase
      if (op == bfeu_pkg::OP_OPEN) open++;
      if (op == bfeu_pkg::OP_CLOSE) begin
        // usually clear the cell so the loop is left
        if ($urandom_range(2) != 0) add_char(bfeu_pkg::OP_COMMA, 8'h00);
        open--;
      end
      add_char(op, rand_byte());
    end
    while (open != 0) begin
      if ($urandom_range(2) != 0) add_char(bfeu_pkg::OP_COMMA, 8'h00);
      add_char(bfeu_pkg::OP_CLOSE, rand_byte());
      open--;
    end
  endtask

  // Fully random characters at random offsets
  task automatic gen_noise(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      prog_pos = bfeu_pkg::pos_t'($urandom_range(16'hFFFF));
      add_char(8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  // Unbalanced bracket soup
  task automatic gen_brackets(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(2))
        0:       add_char(bfeu_pkg::OP_OPEN, rand_byte());
        1:       add_char(bfeu_pkg::OP_CLOSE, rand_byte());
        default: add_char(bfeu_pkg::OP_COMMA, rand_byte());
      endcase
    end
  endtask

  // Wait until everything queued has been accepted and answered
  task automatic wait_idle();
    while (pending_chars.size() != 0 || item_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Close any open skip region; only valid right after wait_idle
  task automatic leave_skip();
    int unsigned depth;
    depth = skip_level;
    repeat (depth) add_char(bfeu_pkg::OP_CLOSE, 8'h00);
  endtask

  initial begin : stimulus
    int unsigned send_idle_by_phase [4];
    int unsigned recv_stall_by_phase [4];
    int unsigned pick;

    send_idle_by_phase  = '{0, 88, 0, 13};
    recv_stall_by_phase = '{0, 0, 88, 13};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corner cases from a cleared tape
    prog_pos = 16'h0000;
    add_char(bfeu_pkg::OP_DOT, 8'h00);      // cleared cell reads zero
    add_char(bfeu_pkg::OP_MINUS, 8'h00);    // wraps to 0xFF
    add_char(bfeu_pkg::OP_DOT, 8'h00);
    add_char(bfeu_pkg::OP_PLUS, 8'h00);     // wraps back to zero
    add_char(bfeu_pkg::OP_LEFT, 8'hFF);     // pointer already at zero
    add_char(bfeu_pkg::OP_COMMA, 8'h80);
    add_char(bfeu_pkg::OP_CLOSE, 8'h00);    // unmatched close on a nonzero cell
    add_char(bfeu_pkg::OP_OPEN, 8'h00);     // push
    add_char(bfeu_pkg::OP_CLOSE, 8'h00);    // jump back
    add_char(bfeu_pkg::OP_COMMA, 8'h00);
    add_char(bfeu_pkg::OP_CLOSE, 8'h00);    // pop
    add_char(bfeu_pkg::OP_CLOSE, 8'h00);    // unmatched close on a zero cell
    add_char(bfeu_pkg::OP_OPEN, 8'h00);     // zero cell: skip
    add_char(bfeu_pkg::OP_PLUS, 8'h00);     // ignored while skipping
    add_char(bfeu_pkg::OP_OPEN, 8'h00);
    add_char(bfeu_pkg::OP_CLOSE, 8'h00);
    add_char(bfeu_pkg::OP_CLOSE, 8'h00);    // skip ends
    add_char(bfeu_pkg::OP_DOT, 8'h00);
    prog_pos = 16'hFFFE;
    add_char(bfeu_pkg::OP_COMMA, 8'h7F);
    add_char(bfeu_pkg::OP_OPEN, 8'h00);     // return offset wraps to zero
    add_char(bfeu_pkg::OP_CLOSE, 8'h00);
    add_char(bfeu_pkg::OP_COMMA, 8'h00);
    add_char(bfeu_pkg::OP_CLOSE, 8'h00);
    add_char(8'h00, 8'hFF);                 // ignored codes at both ends
    add_char(8'hFF, 8'h00);
    wait_idle();

    for (int unsigned ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_idle_by_phase[ph];
      recv_stall_pct = recv_stall_by_phase[ph];
      act_count = 0;
      leave_skip();
      if (ph == 0) begin
        // nest past the stack limit, then unwind past empty on a zero cell
        add_char(bfeu_pkg::OP_COMMA, 8'($urandom_range(1, 255)));
        repeat (bfeu_pkg::STACK_DEPTH + 2) add_char(bfeu_pkg::OP_OPEN, 8'h00);
        add_char(bfeu_pkg::OP_COMMA, 8'h00);
        repeat (bfeu_pkg::STACK_DEPTH + 3) add_char(bfeu_pkg::OP_CLOSE, 8'h00);
        // walk to the tape top and push past it
        repeat (bfeu_pkg::TAPE_DEPTH + 2) add_char(bfeu_pkg::OP_RIGHT, 8'h00);
        add_char(bfeu_pkg::OP_COMMA, 8'hA5);
        add_char(bfeu_pkg::OP_PLUS, 8'h00);
        add_char(bfeu_pkg::OP_DOT, 8'h00);
        repeat (4) add_char(bfeu_pkg::OP_LEFT, 8'h00);
        add_char(bfeu_pkg::OP_DOT, 8'h00);
      end
      while (act_count < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) gen_program($urandom_range(4, 30));
        else if (pick < 85) gen_noise($urandom_range(1, 6));
        else gen_brackets($urandom_range(2, 12));
      end
      // long result hold-off while the sender keeps pushing
      if (ph == 0) hold_reqs++;
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
